[src/assert_macros.svh]
// Assertion helpers shared by the RTL. They sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define RSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition must never be true.
`define RSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/rss_pkg.sv]
package rss_pkg;

  // Output color format: unsigned fixed point with twelve fraction bits.
  localparam int OUT_FRAC = 12;
  localparam int ONE      = 1 << OUT_FRAC;

  // Sky target colors (0.5, 0.7 and 1.0).
  localparam logic [12:0] SKY_R = 13'd2048;
  localparam logic [12:0] SKY_G = 13'd2867;
  localparam logic [12:0] SKY_B = 13'd4096;

  // Discriminant square root: 67-bit radicand, 34-bit root.
  localparam int DISC_W  = 67;
  localparam int DROOT_W = 34;

  // Vector length square root: 58-bit radicand, 29-bit root.
  localparam int LEN_W   = 58;
  localparam int LROOT_W = 29;

  // Normal components after scaling, dividend and quotient of the divider row.
  localparam int M_W   = 28;
  localparam int NUM_W = 41;
  localparam int Q_W   = 13;
  localparam int LANES = 3;

  // Sphere register indexes on the configuration port.
  typedef enum logic [2:0] {
    CFG_CX  = 3'd0,
    CFG_CY  = 3'd1,
    CFG_CZ  = 3'd2,
    CFG_RAD = 3'd3
  } cfg_reg_t;

endpackage

[src/rss_sqrt_cell.sv]
module rss_sqrt_cell #(
  parameter int W   = 58,
  parameter int RW  = 29,
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [W-1:0]  rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [W-1:0]  rem_o,
  output logic [RW-1:0] root_o,
  output logic [PW-1:0] pay_o
);

  logic [W:0]    trial;
  logic          take;
  logic [W-1:0]  rem_nxt;
  logic [RW-1:0] root_nxt;

  logic          valid_r;
  logic [W-1:0]  rem_r;
  logic [RW-1:0] root_r;
  logic [PW-1:0] pay_r;

  // The remainder holds radicand minus root squared. Setting this bit of the root
  // costs 2*root*2^BIT + 2^(2*BIT), and the root has no bits at or below BIT yet.
  always_comb begin
    trial    = ((W+1)'(root_i) << (BIT + 1)) | ((W+1)'(1) << (2 * BIT));
    take     = {1'b0, rem_i} >= trial;
    rem_nxt  = take ? W'({1'b0, rem_i} - trial) : rem_i;
    root_nxt = take ? (root_i | (RW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    pay_r  <= pay_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign pay_o   = pay_r;

endmodule

[src/rss_div_cell.sv]
module rss_div_cell import rss_pkg::*; #(
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]   rem_i,
  input  logic [LANES-1:0][Q_W-1:0]     q_i,
  input  logic [LROOT_W-1:0]            len_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          valid_o,
  output logic [LANES-1:0][NUM_W-1:0]   rem_o,
  output logic [LANES-1:0][Q_W-1:0]     q_o,
  output logic [LROOT_W-1:0]            len_o,
  output logic [PW-1:0]                 pay_o
);

  logic [NUM_W-1:0]                trial;
  logic [LANES-1:0][NUM_W-1:0]     rem_nxt;
  logic [LANES-1:0][Q_W-1:0]       q_nxt;

  logic                            valid_r;
  logic [LANES-1:0][NUM_W-1:0]     rem_r;
  logic [LANES-1:0][Q_W-1:0]       q_r;
  logic [LROOT_W-1:0]              len_r;
  logic [PW-1:0]                   pay_r;

  // All lanes share one divisor; each lane decides one quotient bit.
  always_comb begin
    trial = NUM_W'(len_i) << BIT;
    for (int l = 0; l < LANES; l++) begin
      if (rem_i[l] >= trial) begin
        rem_nxt[l] = rem_i[l] - trial;
        q_nxt[l]   = q_i[l] | (Q_W'(1) << BIT);
      end else begin
        rem_nxt[l] = rem_i[l];
        q_nxt[l]   = q_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    len_r <= len_i;
    pay_r <= pay_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;
  assign len_o   = len_r;
  assign pay_o   = pay_r;

endmodule

[src/ray_sphere_shade.sv]
// Fully pipelined: one ray may be started in every cycle and busy never rises.
// The pipeline holds 91 register stages, and out_valid is high for one cycle for each
// transferred ray; that stage count is dominated by the 34-cell discriminant root row, the
// 29-cell length root row and the 13-cell divider row.
// Synchronous active-low reset empties the pipeline and loads the sphere registers.
// The receiver cannot stall, so results are never held back.
`include "assert_macros.svh"

module ray_sphere_shade import rss_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic signed [15:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  output logic               out_valid,
  output logic [12:0]        out_red,
  output logic [12:0]        out_green,
  output logic [12:0]        out_blue,
  output logic               out_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef struct packed {
    logic               okdd;
    logic signed [33:0] h;
    logic [31:0]        dd;
    logic [2:0][15:0]   d;
    logic [2:0][16:0]   oc;
  } ray_pay_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] d1;
    logic [31:0] dd;
  } side_t;

  typedef struct packed {
    logic                    hit;
    logic [2:0]              sgn;
    logic [2:0][M_W-1:0]     m;
  } len_pay_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] sgn;
    logic       lenzero;
  } div_pay_t;

  localparam int PA_W = $bits(ray_pay_t);
  localparam int PB_W = $bits(len_pay_t);
  localparam int PC_W = $bits(div_pay_t);

  localparam int CZ_RAW = -(1 << FRAC_BITS);
  localparam int CZ_RST = (CZ_RAW < -32768) ? -32768 : CZ_RAW;
  localparam int RR_RAW = 1 << (FRAC_BITS - 1);
  localparam int RR_RST = (RR_RAW > 32767) ? 32767 : RR_RAW;

  // Sphere registers.
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic [14:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= 16'(CZ_RST);
      rad_r <= 15'(RR_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CX:  cx_r  <= cfg_data;
        CFG_CY:  cy_r  <= cfg_data;
        CFG_CZ:  cz_r  <= cfg_data;
        CFG_RAD: rad_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: capture and origin relative to center.
  logic               s1_v_r;
  logic signed [15:0] s1_d_r  [3];
  logic signed [16:0] s1_oc_r [3];

  // Stage 2: products.
  logic               s2_v_r;
  logic [30:0]        s2_dd_r [3];
  logic signed [32:0] s2_h_r  [3];
  logic [31:0]        s2_cc_r [3];
  logic [29:0]        s2_rr_r;
  logic signed [15:0] s2_d_r  [3];
  logic signed [16:0] s2_oc_r [3];
  logic signed [31:0] dsq     [3];
  logic signed [32:0] dho     [3];
  logic signed [33:0] osq     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsq[i] = s1_d_r[i] * s1_d_r[i];
      dho[i] = s1_d_r[i] * s1_oc_r[i];
      osq[i] = s1_oc_r[i] * s1_oc_r[i];
    end
  end

  // Stage 3: dot products.
  logic               s3_v_r;
  ray_pay_t           s3_pa_nxt, s3_pa_r;
  logic signed [34:0] s3_c_nxt, s3_c_r;

  always_comb begin
    s3_pa_nxt.okdd = 1'b0;
    s3_pa_nxt.dd   = 32'(s2_dd_r[0]) + 32'(s2_dd_r[1]) + 32'(s2_dd_r[2]);
    s3_pa_nxt.h    = 34'(s2_h_r[0]) + 34'(s2_h_r[1]) + 34'(s2_h_r[2]);
    for (int i = 0; i < 3; i++) begin
      s3_pa_nxt.d[i]  = s2_d_r[i];
      s3_pa_nxt.oc[i] = s2_oc_r[i];
    end
    s3_c_nxt = $signed(35'(s2_cc_r[0]) + 35'(s2_cc_r[1]) + 35'(s2_cc_r[2])
                       - 35'(s2_rr_r));
  end

  // Stage 4: partial products of h*h and a*|c|.
  logic        s4_v_r;
  ray_pay_t    s4_pa_r;
  logic        s4_cneg_r;
  logic [32:0] habs;
  logic [33:0] cabs;
  logic [48:0] s4_hhh_nxt, s4_hhh_r;
  logic [49:0] s4_hhl_nxt, s4_hhl_r;
  logic [48:0] s4_ach_nxt, s4_ach_r;
  logic [48:0] s4_acl_nxt, s4_acl_r;

  always_comb begin
    habs       = s3_pa_r.h[33] ? 33'(-s3_pa_r.h) : s3_pa_r.h[32:0];
    cabs       = s3_c_r[34] ? 34'(-s3_c_r) : s3_c_r[33:0];
    s4_hhh_nxt = 49'(habs[32:17]) * 49'(habs);
    s4_hhl_nxt = 50'(habs[16:0]) * 50'(habs);
    s4_ach_nxt = 49'(cabs[33:17]) * 49'(s3_pa_r.dd);
    s4_acl_nxt = 49'(cabs[16:0]) * 49'(s3_pa_r.dd);
  end

  // Stage 5: partial products summed.
  logic        s5_v_r;
  ray_pay_t    s5_pa_r;
  logic        s5_cneg_r;
  logic [65:0] s5_hh_r, s5_ac_r;

  // Stage 6: discriminant.
  logic              s6_v_r;
  ray_pay_t          s6_pa_nxt, s6_pa_r;
  logic [DISC_W-1:0] s6_disc_nxt, s6_disc_r;

  always_comb begin
    s6_pa_nxt      = s5_pa_r;
    s6_pa_nxt.okdd = (s5_cneg_r || (s5_ac_r <= s5_hh_r)) && (s5_pa_r.dd != '0);
    s6_disc_nxt    = s5_cneg_r ? (DISC_W'(s5_hh_r) + DISC_W'(s5_ac_r))
                               : (DISC_W'(s5_hh_r) - DISC_W'(s5_ac_r));
  end

  // Discriminant square root row.
  logic               ds_v    [DROOT_W+1];
  logic [DISC_W-1:0]  ds_rem  [DROOT_W+1];
  logic [DROOT_W-1:0] ds_root [DROOT_W+1];
  logic [PA_W-1:0]    ds_pay  [DROOT_W+1];

  assign ds_v[0]    = s6_v_r;
  assign ds_rem[0]  = s6_disc_r;
  assign ds_root[0] = '0;
  assign ds_pay[0]  = s6_pa_r;

  for (genvar k = 0; k < DROOT_W; k++) begin : g_dsqrt
    rss_sqrt_cell #(
      .W   (DISC_W),
      .RW  (DROOT_W),
      .BIT (DROOT_W - 1 - k),
      .PW  (PA_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (ds_v[k]),
      .rem_i   (ds_rem[k]),
      .root_i  (ds_root[k]),
      .pay_i   (ds_pay[k]),
      .valid_o (ds_v[k+1]),
      .rem_o   (ds_rem[k+1]),
      .root_o  (ds_root[k+1]),
      .pay_o   (ds_pay[k+1])
    );
  end

  // Near root numerator and hit decision.
  ray_pay_t           ds_end;
  logic signed [35:0] num_s;
  logic               n0_v_r;
  ray_pay_t           n0_pa_r;
  logic [32:0]        n0_num_r;
  logic               n0_hit_nxt, n0_hit_r;

  always_comb begin
    ds_end     = ray_pay_t'(ds_pay[DROOT_W]);
    num_s      = -36'(ds_end.h) - $signed({2'b00, ds_root[DROOT_W]});
    n0_hit_nxt = ds_end.okdd && !num_s[35] && (num_s != '0);
  end

  // Normal direction a*OC + num*D: products, then sum.
  logic               v1_v_r;
  logic signed [49:0] v1_p1_r [3];
  logic signed [49:0] v1_p2_r [3];
  side_t              v1_sd_r;
  logic signed [49:0] p1      [3];
  logic signed [49:0] p2      [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i] = $signed(n0_pa_r.oc[i]) * $signed({1'b0, n0_pa_r.dd});
      p2[i] = $signed(n0_pa_r.d[i]) * $signed({1'b0, n0_num_r});
    end
  end

  logic               v2_v_r;
  logic signed [50:0] v2_v_r_vec [3];
  side_t              v2_sd_r;

  // Scaling of the normal: magnitudes shifted together until all are below 2^28,
  // done as a binary search over the shift amount in two stages.
  logic        n1_v_r;
  logic [49:0] n1_m_nxt [3];
  logic [49:0] n1_m_r   [3];
  logic [2:0]  n1_s_nxt, n1_s_r;
  side_t       n1_sd_r;
  logic [49:0] mx1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_m_nxt[i] = v2_v_r_vec[i][50] ? 50'(-v2_v_r_vec[i]) : v2_v_r_vec[i][49:0];
      n1_s_nxt[i] = v2_v_r_vec[i][50];
    end
    mx1 = n1_m_nxt[0] | n1_m_nxt[1] | n1_m_nxt[2];
    if (|mx1[49:43]) begin
      for (int i = 0; i < 3; i++) n1_m_nxt[i] = n1_m_nxt[i] >> 16;
      mx1 = mx1 >> 16;
    end
    if (|mx1[49:35]) begin
      for (int i = 0; i < 3; i++) n1_m_nxt[i] = n1_m_nxt[i] >> 8;
    end
  end

  logic           n2_v_r;
  logic [M_W-1:0] n2_m_nxt [3];
  logic [M_W-1:0] n2_m_r   [3];
  logic [2:0]     n2_s_r;
  side_t          n2_sd_r;
  logic [49:0]    t2 [3];
  logic [49:0]    mx2;

  always_comb begin
    for (int i = 0; i < 3; i++) t2[i] = n1_m_r[i];
    mx2 = t2[0] | t2[1] | t2[2];
    if (|mx2[49:31]) begin
      for (int i = 0; i < 3; i++) t2[i] = t2[i] >> 4;
      mx2 = mx2 >> 4;
    end
    if (|mx2[49:29]) begin
      for (int i = 0; i < 3; i++) t2[i] = t2[i] >> 2;
      mx2 = mx2 >> 2;
    end
    if (|mx2[49:28]) begin
      for (int i = 0; i < 3; i++) t2[i] = t2[i] >> 1;
    end
    for (int i = 0; i < 3; i++) n2_m_nxt[i] = t2[i][M_W-1:0];
  end

  // Squares of the scaled normal.
  logic               n3_v_r;
  logic [2*M_W-1:0]   n3_sq_r [3];
  logic [M_W-1:0]     n3_m_r  [3];
  logic [2:0]         n3_s_r;
  side_t              n3_sd_r;

  // Length radicand: the normal on a hit, the ray direction otherwise.
  logic             n4_v_r;
  logic [LEN_W-1:0] n4_rad_nxt, n4_rad_r;
  len_pay_t         n4_pb_nxt, n4_pb_r;
  logic [15:0]      d1_mag;

  always_comb begin
    d1_mag = n3_sd_r.d1[15] ? 16'(-$signed(n3_sd_r.d1)) : n3_sd_r.d1;
    n4_pb_nxt.hit = n3_sd_r.hit;
    if (n3_sd_r.hit) begin
      n4_rad_nxt = LEN_W'(n3_sq_r[0]) + LEN_W'(n3_sq_r[1]) + LEN_W'(n3_sq_r[2]);
      n4_pb_nxt.sgn = n3_s_r;
      for (int i = 0; i < 3; i++) n4_pb_nxt.m[i] = n3_m_r[i];
    end else begin
      n4_rad_nxt    = LEN_W'(n3_sd_r.dd);
      n4_pb_nxt.sgn = {1'b0, n3_sd_r.d1[15], 1'b0};
      n4_pb_nxt.m[0] = '0;
      n4_pb_nxt.m[1] = M_W'(d1_mag);
      n4_pb_nxt.m[2] = '0;
    end
  end

  // Length square root row.
  logic               ls_v    [LROOT_W+1];
  logic [LEN_W-1:0]   ls_rem  [LROOT_W+1];
  logic [LROOT_W-1:0] ls_root [LROOT_W+1];
  logic [PB_W-1:0]    ls_pay  [LROOT_W+1];

  assign ls_v[0]    = n4_v_r;
  assign ls_rem[0]  = n4_rad_r;
  assign ls_root[0] = '0;
  assign ls_pay[0]  = n4_pb_r;

  for (genvar k = 0; k < LROOT_W; k++) begin : g_lsqrt
    rss_sqrt_cell #(
      .W   (LEN_W),
      .RW  (LROOT_W),
      .BIT (LROOT_W - 1 - k),
      .PW  (PB_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (ls_v[k]),
      .rem_i   (ls_rem[k]),
      .root_i  (ls_root[k]),
      .pay_i   (ls_pay[k]),
      .valid_o (ls_v[k+1]),
      .rem_o   (ls_rem[k+1]),
      .root_o  (ls_root[k+1]),
      .pay_o   (ls_pay[k+1])
    );
  end

  // Rounded dividends m*4096 + len/2.
  len_pay_t                    ls_end;
  logic [LROOT_W-1:0]          ls_len;
  logic                        d0_v_r;
  logic [LANES-1:0][NUM_W-1:0] d0_num_nxt, d0_num_r;
  logic [LROOT_W-1:0]          d0_len_r;
  div_pay_t                    d0_pc_nxt, d0_pc_r;

  always_comb begin
    ls_end = len_pay_t'(ls_pay[LROOT_W]);
    ls_len = ls_root[LROOT_W];
    for (int i = 0; i < LANES; i++) begin
      d0_num_nxt[i] = (NUM_W'(ls_end.m[i]) << OUT_FRAC) + NUM_W'(ls_len >> 1);
    end
    d0_pc_nxt.hit     = ls_end.hit;
    d0_pc_nxt.sgn     = ls_end.sgn;
    d0_pc_nxt.lenzero = (ls_len == '0);
  end

  // Divider row.
  logic                        dv_v   [Q_W+1];
  logic [LANES-1:0][NUM_W-1:0] dv_rem [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   dv_q   [Q_W+1];
  logic [LROOT_W-1:0]          dv_len [Q_W+1];
  logic [PC_W-1:0]             dv_pay [Q_W+1];

  assign dv_v[0]   = d0_v_r;
  assign dv_rem[0] = d0_num_r;
  assign dv_q[0]   = '0;
  assign dv_len[0] = d0_len_r;
  assign dv_pay[0] = d0_pc_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rss_div_cell #(
      .BIT (Q_W - 1 - k),
      .PW  (PC_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_v[k]),
      .rem_i   (dv_rem[k]),
      .q_i     (dv_q[k]),
      .len_i   (dv_len[k]),
      .pay_i   (dv_pay[k]),
      .valid_o (dv_v[k+1]),
      .rem_o   (dv_rem[k+1]),
      .q_o     (dv_q[k+1]),
      .len_o   (dv_len[k+1]),
      .pay_o   (dv_pay[k+1])
    );
  end

  // Unit components to colors.
  div_pay_t    dv_end;
  logic [12:0] qc   [3];
  logic [13:0] hsum [3];
  logic [12:0] hp   [3];
  logic [12:0] kf;
  logic [25:0] sky_r_acc, sky_g_acc, sky_b_acc;
  logic        out_valid_r;
  logic [12:0] out_red_nxt, out_green_nxt, out_blue_nxt;
  logic [12:0] out_red_r, out_green_r, out_blue_r;
  logic        out_hit_r;

  always_comb begin
    dv_end = div_pay_t'(dv_pay[Q_W]);
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[Q_W][i] > 13'(ONE)) ? 13'(ONE) : dv_q[Q_W][i];
      if (dv_end.lenzero) begin
        hsum[i] = 14'(ONE + 1);
      end else if (dv_end.sgn[i]) begin
        hsum[i] = 14'(ONE + 1) - 14'(qc[i]);
      end else begin
        hsum[i] = 14'(ONE + 1) + 14'(qc[i]);
      end
      hp[i] = hsum[i][13:1];
    end
    kf        = hp[1];
    sky_r_acc = (26'(13'(ONE) - kf) << OUT_FRAC) + 26'(SKY_R) * 26'(kf) + 26'(ONE / 2);
    sky_g_acc = (26'(13'(ONE) - kf) << OUT_FRAC) + 26'(SKY_G) * 26'(kf) + 26'(ONE / 2);
    sky_b_acc = (26'(13'(ONE) - kf) << OUT_FRAC) + 26'(SKY_B) * 26'(kf) + 26'(ONE / 2);
    if (dv_end.hit) begin
      out_red_nxt   = hp[0];
      out_green_nxt = hp[1];
      out_blue_nxt  = hp[2];
    end else begin
      out_red_nxt   = sky_r_acc[24:12];
      out_green_nxt = sky_g_acc[24:12];
      out_blue_nxt  = sky_b_acc[24:12];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      n0_v_r      <= 1'b0;
      v1_v_r      <= 1'b0;
      v2_v_r      <= 1'b0;
      n1_v_r      <= 1'b0;
      n2_v_r      <= 1'b0;
      n3_v_r      <= 1'b0;
      n4_v_r      <= 1'b0;
      d0_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= start && !busy;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      n0_v_r      <= ds_v[DROOT_W];
      v1_v_r      <= n0_v_r;
      v2_v_r      <= v1_v_r;
      n1_v_r      <= v2_v_r;
      n2_v_r      <= n1_v_r;
      n3_v_r      <= n2_v_r;
      n4_v_r      <= n3_v_r;
      d0_v_r      <= ls_v[LROOT_W];
      out_valid_r <= dv_v[Q_W];
    end
  end

  // Pipeline data.
  always_ff @(posedge clk) begin
    s1_d_r[0]  <= in_dir_x;
    s1_d_r[1]  <= in_dir_y;
    s1_d_r[2]  <= in_dir_z;
    s1_oc_r[0] <= $signed({in_origin_x[15], in_origin_x}) - $signed({cx_r[15], cx_r});
    s1_oc_r[1] <= $signed({in_origin_y[15], in_origin_y}) - $signed({cy_r[15], cy_r});
    s1_oc_r[2] <= $signed({in_origin_z[15], in_origin_z}) - $signed({cz_r[15], cz_r});

    for (int i = 0; i < 3; i++) begin
      s2_dd_r[i] <= dsq[i][30:0];
      s2_h_r[i]  <= dho[i];
      s2_cc_r[i] <= osq[i][31:0];
      s2_d_r[i]  <= s1_d_r[i];
      s2_oc_r[i] <= s1_oc_r[i];
    end
    s2_rr_r <= rad_r * rad_r;

    s3_pa_r <= s3_pa_nxt;
    s3_c_r  <= s3_c_nxt;

    s4_pa_r   <= s3_pa_r;
    s4_cneg_r <= s3_c_r[34];
    s4_hhh_r  <= s4_hhh_nxt;
    s4_hhl_r  <= s4_hhl_nxt;
    s4_ach_r  <= s4_ach_nxt;
    s4_acl_r  <= s4_acl_nxt;

    s5_pa_r   <= s4_pa_r;
    s5_cneg_r <= s4_cneg_r;
    s5_hh_r   <= (66'(s4_hhh_r) << 17) + 66'(s4_hhl_r);
    s5_ac_r   <= (66'(s4_ach_r) << 17) + 66'(s4_acl_r);

    s6_pa_r   <= s6_pa_nxt;
    s6_disc_r <= s6_disc_nxt;

    n0_pa_r  <= ds_end;
    n0_num_r <= num_s[32:0];
    n0_hit_r <= n0_hit_nxt;

    for (int i = 0; i < 3; i++) begin
      v1_p1_r[i] <= p1[i];
      v1_p2_r[i] <= p2[i];
    end
    v1_sd_r.hit <= n0_hit_r;
    v1_sd_r.d1  <= n0_pa_r.d[1];
    v1_sd_r.dd  <= n0_pa_r.dd;

    for (int i = 0; i < 3; i++) begin
      v2_v_r_vec[i] <= 51'(v1_p1_r[i]) + 51'(v1_p2_r[i]);
    end
    v2_sd_r <= v1_sd_r;

    for (int i = 0; i < 3; i++) n1_m_r[i] <= n1_m_nxt[i];
    n1_s_r  <= n1_s_nxt;
    n1_sd_r <= v2_sd_r;

    for (int i = 0; i < 3; i++) n2_m_r[i] <= n2_m_nxt[i];
    n2_s_r  <= n1_s_r;
    n2_sd_r <= n1_sd_r;

    for (int i = 0; i < 3; i++) begin
      n3_sq_r[i] <= (2*M_W)'(n2_m_r[i]) * (2*M_W)'(n2_m_r[i]);
      n3_m_r[i]  <= n2_m_r[i];
    end
    n3_s_r  <= n2_s_r;
    n3_sd_r <= n2_sd_r;

    n4_rad_r <= n4_rad_nxt;
    n4_pb_r  <= n4_pb_nxt;

    d0_num_r <= d0_num_nxt;
    d0_len_r <= ls_len;
    d0_pc_r  <= d0_pc_nxt;

    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_hit_r   <= dv_end.hit;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_hit   = out_hit_r;

  logic quot_over;
  logic out_in_range;

  assign quot_over    = (dv_q[Q_W][0] > 13'(ONE)) || (dv_q[Q_W][1] > 13'(ONE)) ||
                        (dv_q[Q_W][2] > 13'(ONE));
  assign out_in_range = (out_red <= 13'(ONE)) && (out_green <= 13'(ONE)) &&
                        (out_blue <= 13'(ONE));

  // A normal component never exceeds the length, so no rounded quotient passes one.
  `RSS_ASSERT_NEVER(a_quot_bound, dv_v[Q_W] && !dv_end.lenzero && quot_over, "divider quotient above one")
  // Every channel of every transfer stays within zero to one.
  `RSS_ASSERT_IMPL(a_out_range, out_valid, out_in_range, "color channel out of range")
  // The sky blends toward full blue, so blue is exactly one on a miss.
  `RSS_ASSERT_IMPL(a_sky_blue, out_valid && !out_hit, out_blue == 13'(ONE), "sky blue not one")

endmodule
